FILE: hw/rtl/iparp_pkg.sv
// ----------------------------------------------------------------------------
// iparp_pkg
// Shared types, table sizes and codes for the IPv4 route and neighbour
// lookup engine.
// ----------------------------------------------------------------------------
package iparp_pkg;

  // Table sizes
  localparam int unsigned ROUTE_ENTRIES     = 1024;
  localparam int unsigned NEIGHBOUR_ENTRIES = 16;

  localparam int unsigned RouteAw = $clog2(ROUTE_ENTRIES);
  localparam int unsigned RouteCw = $clog2(ROUTE_ENTRIES + 1);
  localparam int unsigned NbrAw   = $clog2(NEIGHBOUR_ENTRIES);
  localparam int unsigned NbrCw   = $clog2(NEIGHBOUR_ENTRIES + 1);

  // Item operation codes
  localparam logic [1:0] OP_LOAD_ROUTE = 2'd0;
  localparam logic [1:0] OP_LOAD_NBR   = 2'd1;
  localparam logic [1:0] OP_LOOKUP     = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_FOUND    = 3'd0;
  localparam logic [2:0] STAT_NO_ROUTE = 3'd1;
  localparam logic [2:0] STAT_NO_NBR   = 3'd2;
  localparam logic [2:0] STAT_LOADED   = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [31:0] hop_address;
    logic [1:0]  egress_port;
    logic [47:0] hw_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] gateway;
    logic [1:0]  out_port;
    logic [47:0] dest_mac;
  } rsp_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [1:0]  port;
  } route_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } nbr_t;

endpackage

FILE: hw/rtl/iparp_ram.sv
// ----------------------------------------------------------------------------
// iparp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module iparp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ipv4_route_and_arp_lookup.sv
// ----------------------------------------------------------------------------
// ipv4_route_and_arp_lookup
// Route and neighbour table engine with longest-mask route selection and
// next-hop MAC resolution.
// ----------------------------------------------------------------------------
// Results: a load shows its result (done_o) in the cycle after start is taken; an
//   unused op is dropped with no result. A lookup with no route loaded answers
//   like a load; otherwise it walks the routes, one route read per cycle, then,
//   once a route is chosen, one neighbour read per cycle until a hit or the end.
// Throughput: one item at a time; busy falls as done_o pulses; no receiver stall.
// Reset: clears both counts and the control state; the tables are left as is.
module ipv4_route_and_arp_lookup (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  iparp_pkg::req_t  req_i,
  output logic             done_o,
  output iparp_pkg::rsp_t  rsp_o
);

  localparam int unsigned RouteAw = iparp_pkg::RouteAw;
  localparam int unsigned RouteCw = iparp_pkg::RouteCw;
  localparam int unsigned NbrAw   = iparp_pkg::NbrAw;
  localparam int unsigned NbrCw   = iparp_pkg::NbrCw;

  // One-hot sequencer: idle, walk the route table, walk the neighbour table.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RSCAN = 3'b010,
    S_NSCAN = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [RouteCw-1:0]   rcnt_q, rcnt_d;
  logic [NbrCw-1:0]     ncnt_q, ncnt_d;
  logic [RouteAw-1:0]   ridx_q, ridx_d;   // route entry whose data is on the RAM output
  logic [NbrAw-1:0]     nidx_q, nidx_d;   // neighbour entry whose data is on the RAM output
  logic                 best_found_q, best_found_d;
  logic                 done_q, done_d;

  // Payload registers, no reset needed
  logic [31:0]          dest_q, dest_d;
  logic [31:0]          best_mask_q, best_mask_d;
  logic [31:0]          best_hop_q, best_hop_d;
  logic [1:0]           best_port_q, best_port_d;
  iparp_pkg::rsp_t      rsp_q, rsp_d;

  // Memory ports
  logic                 route_we, nbr_we;
  logic [RouteAw-1:0]   route_raddr;
  logic [NbrAw-1:0]     nbr_raddr;
  iparp_pkg::route_t    route_wdata, route_rdata;
  iparp_pkg::nbr_t      nbr_wdata, nbr_rdata;

  logic accept;
  logic route_full, nbr_full;
  logic route_hit, route_better, route_last, nbr_hit, nbr_last;

  assign accept     = start && !busy;
  assign route_full = (rcnt_q == RouteCw'(iparp_pkg::ROUTE_ENTRIES));
  assign nbr_full   = (ncnt_q == NbrCw'(iparp_pkg::NEIGHBOUR_ENTRIES));

  // Load data goes straight into the next free slot.
  assign route_wdata = '{prefix: req_i.address, mask: req_i.prefix_mask,
                         hop: req_i.hop_address, port: req_i.egress_port};
  assign nbr_wdata   = '{ip: req_i.address, mac: req_i.hw_address};
  assign route_we    = accept && (req_i.op == iparp_pkg::OP_LOAD_ROUTE) && !route_full;
  assign nbr_we      = accept && (req_i.op == iparp_pkg::OP_LOAD_NBR) && !nbr_full;

  // Prefetch: while scanning, read the entry after the one being checked.
  // Outside a scan, entry 0 is read so that a scan starts with it in hand.
  // A read past the count returns stale data that is never looked at.
  assign route_raddr = (state_q == S_RSCAN) ? ridx_q + RouteAw'(1) : '0;
  assign nbr_raddr   = (state_q == S_NSCAN) ? nidx_q + NbrAw'(1) : '0;

  iparp_ram #(
    .Width ($bits(iparp_pkg::route_t)),
    .Depth (iparp_pkg::ROUTE_ENTRIES)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (route_we),
    .waddr_i (rcnt_q[RouteAw-1:0]),
    .wdata_i (route_wdata),
    .raddr_i (route_raddr),
    .rdata_o (route_rdata)
  );

  iparp_ram #(
    .Width ($bits(iparp_pkg::nbr_t)),
    .Depth (iparp_pkg::NEIGHBOUR_ENTRIES)
  ) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nbr_we),
    .waddr_i (ncnt_q[NbrAw-1:0]),
    .wdata_i (nbr_wdata),
    .raddr_i (nbr_raddr),
    .rdata_o (nbr_rdata)
  );

  // Route match: masked destination equals the prefix. A strictly greater
  // mask replaces the best so far, so the earliest of equal masks stays.
  assign route_hit    = ((dest_q & route_rdata.mask) == route_rdata.prefix);
  assign route_better = route_hit && (!best_found_q || (route_rdata.mask > best_mask_q));
  assign route_last   = ((RouteCw'(ridx_q) + RouteCw'(1)) == rcnt_q);
  assign nbr_hit      = (nbr_rdata.ip == best_hop_q);
  assign nbr_last     = ((NbrCw'(nidx_q) + NbrCw'(1)) == ncnt_q);

  always_comb begin
    state_d      = state_q;
    rcnt_d       = rcnt_q;
    ncnt_d       = ncnt_q;
    ridx_d       = ridx_q;
    nidx_d       = nidx_q;
    best_found_d = best_found_q;
    best_mask_d  = best_mask_q;
    best_hop_d   = best_hop_q;
    best_port_d  = best_port_q;
    dest_d       = dest_q;
    rsp_d        = rsp_q;
    done_d       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.op)
            iparp_pkg::OP_LOAD_ROUTE: begin
              done_d = 1'b1;
              rsp_d  = '{status: route_full ? iparp_pkg::STAT_FULL : iparp_pkg::STAT_LOADED,
                         gateway: '0, out_port: '0, dest_mac: '0};
              if (!route_full) begin
                rcnt_d = rcnt_q + RouteCw'(1);
              end
            end
            iparp_pkg::OP_LOAD_NBR: begin
              done_d = 1'b1;
              rsp_d  = '{status: nbr_full ? iparp_pkg::STAT_FULL : iparp_pkg::STAT_LOADED,
                         gateway: '0, out_port: '0, dest_mac: '0};
              if (!nbr_full) begin
                ncnt_d = ncnt_q + NbrCw'(1);
              end
            end
            iparp_pkg::OP_LOOKUP: begin
              dest_d       = req_i.address;
              best_found_d = 1'b0;
              ridx_d       = '0;
              if (rcnt_q == '0) begin
                done_d = 1'b1;
                rsp_d  = '{status: iparp_pkg::STAT_NO_ROUTE,
                           gateway: '0, out_port: '0, dest_mac: '0};
              end else begin
                state_d = S_RSCAN;
              end
            end
            default: begin
              // Drop the unused op: no state change, no result.
            end
          endcase
        end
      end

      S_RSCAN: begin
        if (route_better) begin
          best_found_d = 1'b1;
          best_mask_d  = route_rdata.mask;
          best_hop_d   = route_rdata.hop;
          best_port_d  = route_rdata.port;
        end
        ridx_d = ridx_q + RouteAw'(1);
        if (route_last) begin
          nidx_d = '0;
          if (!best_found_d) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
            rsp_d   = '{status: iparp_pkg::STAT_NO_ROUTE,
                        gateway: '0, out_port: '0, dest_mac: '0};
          end else if (ncnt_q == '0) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
            rsp_d   = '{status: iparp_pkg::STAT_NO_NBR,
                        gateway: best_hop_d, out_port: best_port_d, dest_mac: '0};
          end else begin
            state_d = S_NSCAN;
          end
        end
      end

      S_NSCAN: begin
        nidx_d = nidx_q + NbrAw'(1);
        if (nbr_hit) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          rsp_d   = '{status: iparp_pkg::STAT_FOUND, gateway: best_hop_q,
                      out_port: best_port_q, dest_mac: nbr_rdata.mac};
        end else if (nbr_last) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          rsp_d   = '{status: iparp_pkg::STAT_NO_NBR, gateway: best_hop_q,
                      out_port: best_port_q, dest_mac: '0};
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rcnt_q       <= '0;
      ncnt_q       <= '0;
      ridx_q       <= '0;
      nidx_q       <= '0;
      best_found_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      rcnt_q       <= rcnt_d;
      ncnt_q       <= ncnt_d;
      ridx_q       <= ridx_d;
      nidx_q       <= nidx_d;
      best_found_q <= best_found_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q      <= dest_d;
    best_mask_q <= best_mask_d;
    best_hop_q  <= best_hop_d;
    best_port_q <= best_port_d;
    rsp_q       <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result follows either a taken item or the end of a table walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(accept) || $past(state_q == S_RSCAN) || $past(state_q == S_NSCAN)))
    else $error("result strobe without a source item");

  // The neighbour walk only runs once a route has been chosen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NSCAN) |-> best_found_q)
    else $error("neighbour walk without a chosen route");

  // Counts never pass the table sizes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rcnt_q <= RouteCw'(iparp_pkg::ROUTE_ENTRIES)) &&
    (ncnt_q <= NbrCw'(iparp_pkg::NEIGHBOUR_ENTRIES)))
    else $error("table count overflow");

  // A route walk that ends with no neighbours or no match returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RSCAN && route_last && ncnt_q == '0) |=> (state_q == S_IDLE && done_q))
    else $error("route walk did not finish");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb - IPv4 route and neighbour lookup engine testbench
// Drives load and lookup items through the start/busy handshake and checks
// each done_o result against a local forwarding predictor, field by field.
// A short stimulus table covers the corners. Random traffic follows, with
// several sender idle rates. At the end the neighbour table is filled past
// capacity.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Op 3 has no name in the package: the block drops it without a result
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Number of counted random items per idle phase
  localparam int PHASE_ITEMS = 120;

  typedef struct {
    iparp_pkg::req_t item;
    bit              typed;
    iparp_pkg::rsp_t want;
  } stim_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  iparp_pkg::req_t req_i;
  logic            done_o;
  iparp_pkg::rsp_t rsp_o;

  // Shadow copy of the forwarding tables, written only on accepted items
  logic [31:0] rt_prefix [iparp_pkg::ROUTE_ENTRIES];
  logic [31:0] rt_mask   [iparp_pkg::ROUTE_ENTRIES];
  logic [31:0] rt_hop    [iparp_pkg::ROUTE_ENTRIES];
  logic [1:0]  rt_port   [iparp_pkg::ROUTE_ENTRIES];
  int          route_total;
  logic [31:0] nb_ip     [iparp_pkg::NEIGHBOUR_ENTRIES];
  logic [47:0] nb_mac    [iparp_pkg::NEIGHBOUR_ENTRIES];
  int          nbr_total;

  // Results still owed by the block, oldest first
  iparp_pkg::rsp_t awaited_rsp_q [$];
  int              errors;
  int              idle_pct;
  logic [31:0]     hop_pool [16];
  stim_row_t       corner_rows [$];

  ipv4_route_and_arp_lookup DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Fail the run if it hangs: far beyond the slowest legal run
  initial begin
    #150_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Work out the result of one accepted item and advance the shadow tables.
  // Return 0 when the item gives no result.
  function automatic bit forward_decision(input iparp_pkg::req_t it,
                                          output iparp_pkg::rsp_t r);
    int best;
    bit hit;
    r    = '0;
    best = 0;
    hit  = 1'b0;
    case (it.op)
      iparp_pkg::OP_LOAD_ROUTE: begin
        if (route_total >= iparp_pkg::ROUTE_ENTRIES) begin
          r.status = iparp_pkg::STAT_FULL;
        end else begin
          rt_prefix[route_total] = it.address;
          rt_mask[route_total]   = it.prefix_mask;
          rt_hop[route_total]    = it.hop_address;
          rt_port[route_total]   = it.egress_port;
          route_total++;
          r.status = iparp_pkg::STAT_LOADED;
        end
        return 1'b1;
      end
      iparp_pkg::OP_LOAD_NBR: begin
        if (nbr_total >= iparp_pkg::NEIGHBOUR_ENTRIES) begin
          r.status = iparp_pkg::STAT_FULL;
        end else begin
          nb_ip[nbr_total]  = it.address;
          nb_mac[nbr_total] = it.hw_address;
          nbr_total++;
          r.status = iparp_pkg::STAT_LOADED;
        end
        return 1'b1;
      end
      iparp_pkg::OP_LOOKUP: begin
        // Longest mask by unsigned value; a strict compare keeps the earliest
        for (int i = 0; i < route_total; i++) begin
          if ((it.address & rt_mask[i]) == rt_prefix[i]) begin
            if (!hit || rt_mask[i] > rt_mask[best]) begin
              best = i;
              hit  = 1'b1;
            end
          end
        end
        if (!hit) begin
          r.status = iparp_pkg::STAT_NO_ROUTE;
          return 1'b1;
        end
        r.status   = iparp_pkg::STAT_NO_NBR;
        r.gateway  = rt_hop[best];
        r.out_port = rt_port[best];
        // First neighbour entry with the hop address wins
        for (int j = nbr_total - 1; j >= 0; j--) begin
          if (nb_ip[j] == rt_hop[best]) begin
            r.status   = iparp_pkg::STAT_FOUND;
            r.dest_mac = nb_mac[j];
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t row(input logic [1:0] op, input logic [31:0] addr,
                                    input logic [31:0] mask, input logic [31:0] hop,
                                    input logic [1:0] port, input logic [47:0] mac,
                                    input bit typed, input logic [2:0] st,
                                    input logic [31:0] nh, input logic [1:0] oport,
                                    input logic [47:0] dmac);
    stim_row_t s;
    s.item  = '{op: op, address: addr, prefix_mask: mask, hop_address: hop,
                egress_port: port, hw_address: mac};
    s.typed = typed;
    s.want  = '{status: st, gateway: nh, out_port: oport, dest_mac: dmac};
    return s;
  endfunction

  // Random item: mostly well-formed loads and lookups that hit loaded routes,
  // with fully random noise and unused ops mixed in
  function automatic iparp_pkg::req_t pick_item();
    iparp_pkg::req_t it;
    logic [63:0]     wide;
    int              sel;
    int              len;
    int              idx;
    wide           = {$urandom, $urandom};
    it.address     = $urandom;
    it.prefix_mask = $urandom;
    it.hop_address = $urandom;
    it.egress_port = 2'($urandom_range(3));
    it.hw_address  = wide[47:0];
    sel = $urandom_range(99);
    if (sel < 28) begin
      it.op = iparp_pkg::OP_LOAD_ROUTE;
      if ($urandom_range(99) < 75) begin
        len            = $urandom_range(32);
        it.prefix_mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
      end
      // Keep most prefixes inside their mask; the rest match only if no prefix bit lies outside it
      if ($urandom_range(99) < 85) it.address = it.address & it.prefix_mask;
      if ($urandom_range(99) < 80) it.hop_address = hop_pool[$urandom_range(15)];
    end else if (sel < 36) begin
      it.op = iparp_pkg::OP_LOAD_NBR;
      if ($urandom_range(99) < 75) it.address = hop_pool[$urandom_range(15)];
    end else if (sel < 93) begin
      it.op = iparp_pkg::OP_LOOKUP;
      if (route_total > 0 && $urandom_range(99) < 75) begin
        idx        = $urandom_range(route_total - 1);
        it.address = (rt_prefix[idx] & rt_mask[idx]) | (it.address & ~rt_mask[idx]);
      end
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // Offer one item from a falling edge; return at the falling edge after it
  // is taken. Typed rows replace the predicted result with their own.
  task automatic send_item(input iparp_pkg::req_t it, input bit typed,
                           input iparp_pkg::rsp_t want);
    iparp_pkg::rsp_t got;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = it;
    do @(posedge clk_i); while (busy);
    if (forward_decision(it, got)) awaited_rsp_q.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  // Hold the sender until every owed result has come, then let a dropped
  // op finish
  task automatic drain_results();
    start = 1'b0;
    while (awaited_rsp_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Results live for one cycle: take each one at the edge that ends it
  always @(posedge clk_i) begin
    iparp_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (awaited_rsp_q.size() == 0) begin
        report_mismatch("result with none owed", 48'(rsp_o.status), '0);
      end else begin
        want = awaited_rsp_q.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch("status", 48'(rsp_o.status), 48'(want.status));
        if (rsp_o.gateway !== want.gateway)
          report_mismatch("gateway", 48'(rsp_o.gateway), 48'(want.gateway));
        if (rsp_o.out_port !== want.out_port)
          report_mismatch("out_port", 48'(rsp_o.out_port), 48'(want.out_port));
        if (rsp_o.dest_mac !== want.dest_mac)
          report_mismatch("dest_mac", rsp_o.dest_mac, want.dest_mac);
      end
    end
  end

  initial begin
    int              counted;
    int              phase_pct [4];
    iparp_pkg::rsp_t none;
    iparp_pkg::rsp_t full_rsp;
    iparp_pkg::req_t it;

    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    errors      = 0;
    route_total = 0;
    nbr_total   = 0;
    idle_pct    = 0;
    none        = '0;
    full_rsp    = '{status: iparp_pkg::STAT_FULL, gateway: '0, out_port: '0,
                    dest_mac: '0};
    phase_pct   = '{0, 49, 16, 0};
    foreach (hop_pool[k]) hop_pool[k] = $urandom;

    // Corner table: empty tables, all-ones and all-zero fields, host and /8
    // routes, a prefix with bits outside its mask, a mask with holes, equal
    // masks, duplicate neighbours and dropped ops
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 2'd0, 48'h0,
                              1, iparp_pkg::STAT_NO_ROUTE, 32'h0, 2'd0, 48'h0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, '1, '1, '1, 2'd3, '1,
                              1, iparp_pkg::STAT_NO_ROUTE, 32'h0, 2'd0, 48'h0));
    corner_rows.push_back(row(OP_UNUSED, '1, '1, '1, 2'd3, '1,
                              0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_ROUTE, '1, '1, '1, 2'd3, '1,
                              1, iparp_pkg::STAT_LOADED, 32'h0, 2'd0, 48'h0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, '1, 32'h0, 32'h0, 2'd0, 48'h0,
                              1, iparp_pkg::STAT_NO_NBR, '1, 2'd3, 48'h0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0, 2'd0,
                              48'h0, 1, iparp_pkg::STAT_NO_ROUTE, 32'h0, 2'd0, 48'h0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_NBR, '1, '1, '1, 2'd3, '1,
                              1, iparp_pkg::STAT_LOADED, 32'h0, 2'd0, 48'h0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, '1, 32'h0, 32'h0, 2'd0, 48'h0,
                              1, iparp_pkg::STAT_FOUND, '1, 2'd3, '1));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_ROUTE, 32'h0A00_0000, 32'hFF00_0000,
                              32'h0, 2'd0, 48'h0, 1, iparp_pkg::STAT_LOADED, 32'h0,
                              2'd0, 48'h0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'h0A12_3456, '1, '1, 2'd3, '1,
                              0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_NBR, 32'h0, 32'h0, 32'h0, 2'd0, 48'h0,
                              1, iparp_pkg::STAT_LOADED, 32'h0, 2'd0, 48'h0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'h0AFF_FFFF, 32'h0, 32'h0, 2'd0,
                              48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_ROUTE, 32'h0A00_00FF, 32'hFFFF_0000,
                              32'hC0A8_0001, 2'd1, 48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'h0A00_00FF, 32'h0, 32'h0, 2'd0,
                              48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_ROUTE, 32'hA0B0_C0D0, 32'hF0F0_F0F0,
                              32'hC0A8_0002, 2'd2, 48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'hA5B5_C5D5, 32'h0, 32'h0, 2'd0,
                              48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_ROUTE, 32'h0A01_0000, 32'hFFFF_0000,
                              32'hC0A8_0001, 2'd1, 48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_ROUTE, 32'h0A01_0000, 32'hFFFF_0000,
                              32'hC0A8_0002, 2'd2, 48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'h0A01_ABCD, 32'h0, 32'h0, 2'd0,
                              48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_NBR, 32'hC0A8_0001, 32'h0, 32'h0, 2'd0,
                              48'h0123_4567_89AB, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOAD_NBR, 32'hC0A8_0001, 32'h0, 32'h0, 2'd0,
                              48'hFEDC_BA98_7654, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'h0A01_ABCD, 32'h0, 32'h0, 2'd0,
                              48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(iparp_pkg::OP_LOOKUP, 32'h5555_5555, 32'h0, 32'h0, 2'd0,
                              48'h0, 0, '0, '0, '0, '0));
    corner_rows.push_back(row(OP_UNUSED, 32'h0, 32'h0, 32'h0, 2'd0, 48'h0,
                              0, '0, '0, '0, '0));

    // Hold reset, then release it away from the rising edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (corner_rows[n]) send_item(corner_rows[n].item, corner_rows[n].typed,
                                       corner_rows[n].want);
    drain_results();

    // Random traffic, one idle rate per phase; drain between phases so the
    // sender also sits idle with nothing in flight
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      counted  = 0;
      while (counted < PHASE_ITEMS) begin
        it = pick_item();
        if (it.op != OP_UNUSED) counted++;
        send_item(it, 1'b0, none);
      end
      drain_results();
    end

    // Fill the neighbour table, then push past capacity and look up
    idle_pct = 16;
    while (nbr_total < iparp_pkg::NEIGHBOUR_ENTRIES) begin
      it         = pick_item();
      it.op      = iparp_pkg::OP_LOAD_NBR;
      it.address = hop_pool[$urandom_range(15)];
      send_item(it, 1'b0, none);
    end
    repeat (3) begin
      it    = pick_item();
      it.op = iparp_pkg::OP_LOAD_NBR;
      send_item(it, 1'b1, full_rsp);
    end
    repeat (8) begin
      it    = pick_item();
      it.op = iparp_pkg::OP_LOOKUP;
      send_item(it, 1'b0, none);
    end
    it    = pick_item();
    it.op = OP_UNUSED;
    send_item(it, 1'b0, none);

    // Wait out what is owed, then a full lookup time for any stray result
    start = 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (iparp_pkg::ROUTE_ENTRIES + iparp_pkg::NEIGHBOUR_ENTRIES + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/iparp_pkg.sv
hw/rtl/iparp_ram.sv
hw/rtl/ipv4_route_and_arp_lookup.sv
sim/tb.sv
